>>> hw/rtl/nrmc_pkg.sv
package nrmc_pkg;

  // Longest line, counted from '$', before it is dropped
  localparam logic [7:0] MAX_LINE = 8'd128;
  localparam logic [7:0] LINE_SAT = 8'd255;
  // Header length including the trailing comma
  localparam logic [2:0] HDR_LEN  = 3'd7;
  localparam logic [7:0] HDR_LINE_LEN = 8'd7;

  localparam logic [4:0] OFFSET_RST = 5'd8;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Field numbers, counted by commas seen (header comma is 1)
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_ALL    = 4'd10;
  localparam logic [3:0] COMMA_SAT  = 4'd15;
  localparam logic [2:0] DIGITS     = 3'd6;
  localparam logic [2:0] CIF_SAT    = 3'd7;

  localparam logic [7:0] HOURS_DAY  = 8'd24;

  // Captured sentence contents handed to the time calculation
  typedef struct packed {
    logic [5:0][3:0] time_dig;
    logic [5:0][3:0] date_dig;
    logic            fix;
    logic            complete;
    logic            bad;
  } nrmc_snap_t;

  typedef struct packed {
    logic [4:0] local_hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] year;
    logic       fix_valid;
    logic       fields_complete;
    logic       format_error;
  } nrmc_result_t;

  function automatic logic header_char_ok(input logic [2:0] pos, input logic [7:0] b);
    logic ok;
    case (pos)
      3'd0:    ok = (b == CH_DOLLAR);
      3'd1:    ok = (b == CH_G);
      3'd2:    ok = (b == CH_P) || (b == CH_N);
      3'd3:    ok = (b == CH_R);
      3'd4:    ok = (b == CH_M);
      3'd5:    ok = (b == CH_C);
      3'd6:    ok = (b == CH_COMMA);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> hw/rtl/nrmc_parser.sv
module nrmc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output logic                emit,
  output nrmc_pkg::nrmc_snap_t snap
);

  logic [2:0]      hdr_r, hdr_nxt;
  logic            in_sent_r, in_sent_nxt;
  logic [3:0]      comma_r, comma_nxt;
  logic [2:0]      cif_r, cif_nxt;
  logic [5:0][3:0] time_r, time_nxt;
  logic [5:0][3:0] date_r, date_nxt;
  logic            fix_r, fix_nxt;
  logic            bad_r, bad_nxt;
  logic [7:0]      len_r, len_nxt;
  logic            cr_r, cr_nxt;

  logic            is_digit;
  logic [3:0]      dval;

  assign is_digit = (rx_byte >= nrmc_pkg::CH_ZERO) && (rx_byte <= nrmc_pkg::CH_NINE);
  assign dval     = is_digit ? 4'(rx_byte - nrmc_pkg::CH_ZERO) : 4'd0;

  always_comb begin
    hdr_nxt     = hdr_r;
    in_sent_nxt = in_sent_r;
    comma_nxt   = comma_r;
    cif_nxt     = cif_r;
    time_nxt    = time_r;
    date_nxt    = date_r;
    fix_nxt     = fix_r;
    bad_nxt     = bad_r;
    len_nxt     = len_r;
    cr_nxt      = cr_r;
    emit        = 1'b0;

    if (!in_sent_r) begin
      if (nrmc_pkg::header_char_ok(hdr_r, rx_byte)) begin
        if (hdr_r == nrmc_pkg::HDR_LEN - 3'd1) begin
          hdr_nxt     = 3'd0;
          in_sent_nxt = 1'b1;
          comma_nxt   = 4'd1;
          cif_nxt     = 3'd0;
          bad_nxt     = 1'b0;
          cr_nxt      = 1'b0;
          len_nxt     = nrmc_pkg::HDR_LINE_LEN;
          time_nxt    = '0;
          date_nxt    = '0;
        end else begin
          hdr_nxt = hdr_r + 3'd1;
        end
      end else begin
        hdr_nxt = (rx_byte == nrmc_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
      end
    end else if (rx_byte == nrmc_pkg::CH_DOLLAR) begin
      // restart hunt with '$' already matched
      in_sent_nxt = 1'b0;
      cr_nxt      = 1'b0;
      hdr_nxt     = 3'd1;
    end else if (rx_byte == nrmc_pkg::CH_LF && cr_r) begin
      emit        = 1'b1;
      in_sent_nxt = 1'b0;
      cr_nxt      = 1'b0;
      hdr_nxt     = 3'd0;
    end else begin
      if (rx_byte == nrmc_pkg::CH_CR) begin
        cr_nxt = 1'b1;
      end else begin
        cr_nxt = 1'b0;
        if (rx_byte == nrmc_pkg::CH_COMMA) begin
          if (comma_r < nrmc_pkg::COMMA_SAT) begin
            comma_nxt = comma_r + 4'd1;
          end
          cif_nxt = 3'd0;
        end else begin
          if (comma_r == nrmc_pkg::FLD_TIME && cif_r < nrmc_pkg::DIGITS) begin
            time_nxt[cif_r] = dval;
            if (!is_digit) begin
              bad_nxt = 1'b1;
            end
          end else if (comma_r == nrmc_pkg::FLD_DATE && cif_r < nrmc_pkg::DIGITS) begin
            date_nxt[cif_r] = dval;
            if (!is_digit) begin
              bad_nxt = 1'b1;
            end
          end else if (comma_r == nrmc_pkg::FLD_STATUS && cif_r == 3'd0) begin
            if (rx_byte == nrmc_pkg::CH_A) begin
              fix_nxt = 1'b1;
            end else if (rx_byte == nrmc_pkg::CH_V) begin
              fix_nxt = 1'b0;
            end
          end
          if (cif_r < nrmc_pkg::CIF_SAT) begin
            cif_nxt = cif_r + 3'd1;
          end
        end
      end
      if (len_r < nrmc_pkg::LINE_SAT) begin
        len_nxt = len_r + 8'd1;
      end
      // overlong line: drop it
      if (len_nxt >= nrmc_pkg::MAX_LINE) begin
        in_sent_nxt = 1'b0;
        cr_nxt      = 1'b0;
        hdr_nxt     = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= 3'd0;
      in_sent_r <= 1'b0;
      comma_r   <= 4'd0;
      cif_r     <= 3'd0;
      time_r    <= '0;
      date_r    <= '0;
      fix_r     <= 1'b0;
      bad_r     <= 1'b0;
      len_r     <= 8'd0;
      cr_r      <= 1'b0;
    end else if (step) begin
      hdr_r     <= hdr_nxt;
      in_sent_r <= in_sent_nxt;
      comma_r   <= comma_nxt;
      cif_r     <= cif_nxt;
      time_r    <= time_nxt;
      date_r    <= date_nxt;
      fix_r     <= fix_nxt;
      bad_r     <= bad_nxt;
      len_r     <= len_nxt;
      cr_r      <= cr_nxt;
    end
  end

  assign snap.time_dig = time_r;
  assign snap.date_dig = date_r;
  assign snap.fix      = fix_r;
  assign snap.complete = (comma_r >= nrmc_pkg::FLD_ALL);
  assign snap.bad      = bad_r;

endmodule

>>> hw/rtl/nrmc_time_calc.sv
module nrmc_time_calc (
  input  nrmc_pkg::nrmc_snap_t   snap,
  input  logic [4:0]             utc_offset,
  output nrmc_pkg::nrmc_result_t res
);

  logic [7:0] hour_sum;
  logic [2:0] carry;
  logic [7:0] carry_x24;
  logic [7:0] hour_rem;

  function automatic logic [6:0] pair(input logic [3:0] hi, input logic [3:0] lo);
    return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
  endfunction

  assign hour_sum = {1'b0, pair(snap.time_dig[0], snap.time_dig[1])} + {3'b000, utc_offset};

  // sum is below 135, so the day carry is at most 5
  always_comb begin
    if (hour_sum >= 5 * nrmc_pkg::HOURS_DAY) begin
      carry = 3'd5;
    end else if (hour_sum >= 4 * nrmc_pkg::HOURS_DAY) begin
      carry = 3'd4;
    end else if (hour_sum >= 3 * nrmc_pkg::HOURS_DAY) begin
      carry = 3'd3;
    end else if (hour_sum >= 2 * nrmc_pkg::HOURS_DAY) begin
      carry = 3'd2;
    end else if (hour_sum >= nrmc_pkg::HOURS_DAY) begin
      carry = 3'd1;
    end else begin
      carry = 3'd0;
    end
  end

  assign carry_x24 = {1'b0, carry, 4'b0000} + {2'b00, carry, 3'b000};
  assign hour_rem  = hour_sum - carry_x24;

  assign res.local_hour      = hour_rem[4:0];
  assign res.minute          = pair(snap.time_dig[2], snap.time_dig[3]);
  assign res.second          = pair(snap.time_dig[4], snap.time_dig[5]);
  assign res.day             = pair(snap.date_dig[0], snap.date_dig[1]) + {4'b0000, carry};
  assign res.month           = pair(snap.date_dig[2], snap.date_dig[3]);
  assign res.year            = pair(snap.date_dig[4], snap.date_dig[5]);
  assign res.fix_valid       = snap.fix;
  assign res.fields_complete = snap.complete;
  assign res.format_error    = snap.bad;

endmodule

>>> hw/rtl/nmea_rmc_time_extractor.sv
// NMEA RMC time extractor.
// Input channel (in_valid/in_ready/in_rx_byte): one received character per
// beat. The parser hunts for "$GPRMC," or "$GNRMC,", counts commas and keeps
// the time digits, the status character and the date digits. The LF of a
// CR LF pair ends the sentence and yields one beat on the output channel
// (out_valid/out_ready/out_*): local hour (UTC + offset, mod 24), minute,
// second, day plus hour carry (no month rollover), month, year and flags.
// Other characters yield no output beat.
// Config channel (cfg_valid/cfg_ready/cfg_utc_offset_hours) sets the hour
// offset; always ready, write only while the block is idle.
// Throughput: one character per cycle while the input register is not held.
// The byte sits in an input register, then the parser and time math run
// combinationally into the output register.
// Stall: a pending result in the output register does not block input;
// only a sentence-ending LF arriving while out_ready stays low holds the input
// register, and in_ready drops while that byte is held.
// Reset (rst_n low, synchronous): parser back to header hunt, no fix,
// offset = 8 hours, both registers empty.
module nmea_rmc_time_extractor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_local_hour,
  output logic [6:0] out_minute_out,
  output logic [6:0] out_second_out,
  output logic [6:0] out_day_out,
  output logic [6:0] out_month_out,
  output logic [6:0] out_year_out,
  output logic       out_fix_valid,
  output logic       out_fields_complete,
  output logic       out_format_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_utc_offset_hours
);

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   out_valid_r;
  nrmc_pkg::nrmc_result_t res_r;
  nrmc_pkg::nrmc_result_t res_nxt;
  logic [4:0]             offset_r;

  logic                   emit;
  logic                   out_free;
  logic                   advance;
  nrmc_pkg::nrmc_snap_t   snap;

  // output register can take a beat this cycle
  assign out_free = !out_valid_r || out_ready;
  // held byte is consumed unless it makes a result that has nowhere to go
  assign advance  = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  nrmc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .emit    (emit),
    .snap    (snap)
  );

  nrmc_time_calc u_calc (
    .snap       (snap),
    .utc_offset (offset_r),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= nrmc_pkg::OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= cfg_utc_offset_hours;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_local_hour      = res_r.local_hour;
  assign out_minute_out      = res_r.minute;
  assign out_second_out      = res_r.second;
  assign out_day_out         = res_r.day;
  assign out_month_out       = res_r.month;
  assign out_year_out        = res_r.year;
  assign out_fix_valid       = res_r.fix_valid;
  assign out_fields_complete = res_r.fields_complete;
  assign out_format_error    = res_r.format_error;

  // a finished sentence always lands in the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> out_valid_r)
    else $error("result beat lost");

  // local hour always wrapped
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.local_hour < 5'd24)
    else $error("local hour out of range");

  // empty input register never stalls the sender
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while empty");

  // a held byte is only kept when it carries a result the output cannot take
  a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |-> emit && out_valid_r && !out_ready)
    else $error("byte held without cause");

endmodule
